// ===== hw/rtl/aes128_block_cipher_defines.svh =====
// assertion macros for the aes-128 pipeline
// used by aes_key_exp, aes_round_cell and aes128_block_cipher
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH
`ifndef SYNTH
`define AES_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define AES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AES_ASSERT_NOW(lbl, ante, cons, msg)
`define AES_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/aes_pkg.sv =====
// aes-128 types, s-box tables and round functions
// no dependencies
package aes_pkg;

	typedef logic [127:0] state_t;
	typedef logic [10:0][127:0] rkeys_t;

	typedef struct packed {
		logic valid;
		logic func;
	} ctl_t;

	localparam logic FUNC_ENC = 1'b0;
	localparam logic FUNC_DEC = 1'b1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
		8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
		8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
		8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
		8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
		8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
		8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
		8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
		8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
		8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
		8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
		8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
		8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
		8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
		8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
		8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
		8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
		8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
		8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
		8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
		8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
		8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
		8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
		8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
		8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
		8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
		8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
		8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
		8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
		8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
		8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
		8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
	};

	function automatic logic [7:0] rcon(input logic [3:0] rnd);
		logic [7:0] r;
		unique case (rnd)
			4'd1:    r = 8'h01;
			4'd2:    r = 8'h02;
			4'd3:    r = 8'h04;
			4'd4:    r = 8'h08;
			4'd5:    r = 8'h10;
			4'd6:    r = 8'h20;
			4'd7:    r = 8'h40;
			4'd8:    r = 8'h80;
			4'd9:    r = 8'h1b;
			4'd10:   r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic state_t sub_bytes(input state_t s);
		state_t t;
		for (int i = 0; i < 16; i++) begin
			t[8*i +: 8] = SBOX[s[8*i +: 8]];
		end
		return t;
	endfunction

	function automatic state_t inv_sub_bytes(input state_t s);
		state_t t;
		for (int i = 0; i < 16; i++) begin
			t[8*i +: 8] = INV_SBOX[s[8*i +: 8]];
		end
		return t;
	endfunction

	function automatic state_t shift_rows(input state_t s);
		state_t t;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				t[8*(r+4*c) +: 8] = s[8*(r+4*((c+r)&3)) +: 8];
			end
		end
		return t;
	endfunction

	function automatic state_t inv_shift_rows(input state_t s);
		state_t t;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				t[8*(r+4*((c+r)&3)) +: 8] = s[8*(r+4*c) +: 8];
			end
		end
		return t;
	endfunction

	function automatic state_t mix_columns(input state_t s);
		state_t t;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[32*c +: 8];
			a1 = s[32*c+8 +: 8];
			a2 = s[32*c+16 +: 8];
			a3 = s[32*c+24 +: 8];
			t[32*c +: 8]    = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			t[32*c+8 +: 8]  = xt(a1) ^ xt(a2) ^ a2 ^ a3 ^ a0;
			t[32*c+16 +: 8] = xt(a2) ^ xt(a3) ^ a3 ^ a0 ^ a1;
			t[32*c+24 +: 8] = xt(a3) ^ xt(a0) ^ a0 ^ a1 ^ a2;
		end
		return t;
	endfunction

	function automatic logic [7:0] mul9(input logic [7:0] a);
		return xt(xt(xt(a))) ^ a;
	endfunction

	function automatic logic [7:0] mul11(input logic [7:0] a);
		return xt(xt(xt(a))) ^ xt(a) ^ a;
	endfunction

	function automatic logic [7:0] mul13(input logic [7:0] a);
		return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
	endfunction

	function automatic logic [7:0] mul14(input logic [7:0] a);
		return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
	endfunction

	function automatic state_t inv_mix_columns(input state_t s);
		state_t t;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[32*c +: 8];
			a1 = s[32*c+8 +: 8];
			a2 = s[32*c+16 +: 8];
			a3 = s[32*c+24 +: 8];
			t[32*c +: 8]    = mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3);
			t[32*c+8 +: 8]  = mul14(a1) ^ mul11(a2) ^ mul13(a3) ^ mul9(a0);
			t[32*c+16 +: 8] = mul14(a2) ^ mul11(a3) ^ mul13(a0) ^ mul9(a1);
			t[32*c+24 +: 8] = mul14(a3) ^ mul11(a0) ^ mul13(a1) ^ mul9(a2);
		end
		return t;
	endfunction

	function automatic state_t next_round_key(input state_t k, input logic [3:0] rnd);
		state_t n;
		logic [31:0] tw;
		tw = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]],
			SBOX[k[111:104]] ^ rcon(rnd)};
		n[31:0]   = k[31:0] ^ tw;
		n[63:32]  = k[63:32] ^ n[31:0];
		n[95:64]  = k[95:64] ^ n[63:32];
		n[127:96] = k[127:96] ^ n[95:64];
		return n;
	endfunction

endpackage

// ===== hw/rtl/aes128_block_cipher.sv =====
// AES-128 block cipher: ten round stages in a row behind an initial key-add stage,
// one block accepted per cycle while no key expansion runs and the output is not
// stalled; each stage has its own valid bit, so bubbles close up under back-pressure.
// After reset and after each key write the key expander builds the 11 round keys,
// one per cycle, and in_stall stays high until they are ready.
// Depends on aes_pkg, aes_key_exp, aes_round_cell and aes128_block_cipher_defines.svh.
`include "aes128_block_cipher_defines.svh"
module aes128_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [63:0] block_low,
	input  logic [63:0] block_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_low,
	output logic [63:0] result_high
);
	import aes_pkg::*;

	logic   busy;
	rkeys_t rkeys;
	ctl_t   ctl [11];
	state_t st [11];
	logic   rdy [12];
	ctl_t   ctl_s0;
	state_t state_s0;
	logic   in_acc;

	aes_key_exp u_key (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.rkeys     (rkeys)
	);

	assign rdy[0]   = !ctl_s0.valid || rdy[1];
	assign in_stall = busy || !rdy[0];
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
		end else if (rdy[0]) begin
			ctl_s0 <= '{valid: in_acc, func: func};
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			state_s0 <= {block_high, block_low} ^ ((func == FUNC_DEC) ? rkeys[10] : rkeys[0]);
		end
	end

	assign ctl[0]  = ctl_s0;
	assign st[0]   = state_s0;
	assign rdy[11] = !out_stall;

	for (genvar i = 1; i <= 10; i++) begin : g_round
		aes_round_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.is_last  (i == 10),
			.rk_enc   (rkeys[i]),
			.rk_dec   (rkeys[10-i]),
			.up_ctl   (ctl[i-1]),
			.up_state (st[i-1]),
			.up_ready (rdy[i]),
			.dn_ready (rdy[i+1]),
			.dn_ctl   (ctl[i]),
			.dn_state (st[i])
		);
	end

	assign out_valid   = ctl[10].valid;
	assign result_low  = st[10][63:0];
	assign result_high = st[10][127:64];

	`AES_ASSERT_NOW(a_busy_stall, busy, in_stall, "input taken during key expansion")
	`AES_ASSERT_NEXT(a_in_take, in_acc, ctl_s0.valid, "accepted beat not captured")
	`AES_ASSERT_NEXT(a_cfg_stall, cfg_write, in_stall, "input open right after key write")
endmodule

// ===== hw/rtl/aes_key_exp.sv =====
// key registers and iterative round key expansion, one round key per cycle
// depends on aes_pkg and aes128_block_cipher_defines.svh
`include "aes128_block_cipher_defines.svh"
module aes_key_exp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_write,
	input  logic            cfg_index,
	input  logic [63:0]     cfg_data,
	output logic            busy,
	output aes_pkg::rkeys_t rkeys
);
	import aes_pkg::*;

	logic [63:0] key_low_q, key_high_q;
	logic        busy_q;
	logic [3:0]  cnt_q;
	state_t      cur_q;
	state_t      rk_q [11];
	state_t      nxt;

	assign nxt  = next_round_key(cur_q, cnt_q);
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			busy_q     <= 1'b1;
			cnt_q      <= '0;
		end else if (cfg_write) begin
			if (cfg_index) key_high_q <= cfg_data;
			else key_low_q <= cfg_data;
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd10) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !cfg_write) begin
			if (cnt_q == 4'd0) begin
				rk_q[0] <= {key_high_q, key_low_q};
				cur_q   <= {key_high_q, key_low_q};
			end else begin
				rk_q[cnt_q] <= nxt;
				cur_q       <= nxt;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 11; i++) begin
			rkeys[i] = rk_q[i];
		end
	end

	`AES_ASSERT_NEXT(a_write_busy, cfg_write, busy_q, "key write did not start expansion")
	`AES_ASSERT_NOW(a_cnt_range, busy_q, cnt_q <= 4'd10, "expansion counter out of range")
	`AES_ASSERT_NEXT(a_idle_hold, !busy_q && !cfg_write, !busy_q, "expansion restarted unasked")
endmodule

// ===== hw/rtl/aes_round_cell.sv =====
// one aes round stage for encryption and decryption, with its own valid bit
// depends on aes_pkg and aes128_block_cipher_defines.svh
`include "aes128_block_cipher_defines.svh"
module aes_round_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            is_last,
	input  aes_pkg::state_t rk_enc,
	input  aes_pkg::state_t rk_dec,
	input  aes_pkg::ctl_t   up_ctl,
	input  aes_pkg::state_t up_state,
	output logic            up_ready,
	input  logic            dn_ready,
	output aes_pkg::ctl_t   dn_ctl,
	output aes_pkg::state_t dn_state
);
	import aes_pkg::*;

	ctl_t   ctl_q;
	state_t state_q;
	state_t enc_sr, enc_mc, dec_ks, nxt;

	assign up_ready = !ctl_q.valid || dn_ready;

	always_comb begin
		enc_sr = shift_rows(sub_bytes(up_state));
		enc_mc = is_last ? enc_sr : mix_columns(enc_sr);
		dec_ks = inv_sub_bytes(inv_shift_rows(up_state)) ^ rk_dec;
		if (up_ctl.func == FUNC_DEC) nxt = is_last ? dec_ks : inv_mix_columns(dec_ks);
		else nxt = enc_mc ^ rk_enc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (up_ready) begin
			ctl_q <= up_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_ctl.valid) state_q <= nxt;
	end

	assign dn_ctl   = ctl_q;
	assign dn_state = state_q;

	`AES_ASSERT_NEXT(a_hold, ctl_q.valid && !dn_ready, ctl_q.valid && $stable(state_q),
		"stalled round stage lost its beat")
	`AES_ASSERT_NEXT(a_take, up_ready && up_ctl.valid, ctl_q.valid, "round stage dropped a beat")
	`AES_ASSERT_NOW(a_ready, !ctl_q.valid, up_ready, "empty round stage not ready")
endmodule
